>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold in the same cycle
`define ASSERT_AT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Condition that must be followed by a consequence in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_AT(lbl, clk, rst, prop)
`define ASSERT_NEXT(lbl, clk, rst, cond, cons)

`endif

`endif

>>> hdl/lrd_pkg.sv
// ---------------------------------------------------------------------------
// lrd_pkg
// Shared types and constants of the random range draw block.
// ---------------------------------------------------------------------------
package lrd_pkg;

  // Request codes
  localparam logic [1:0] REQ_RAW    = 2'd0;
  localparam logic [1:0] REQ_RANGE  = 2'd1;
  localparam logic [1:0] REQ_RESEED = 2'd2;

  // Register indexes
  localparam logic CFG_MULTIPLIER = 1'b0;
  localparam logic CFG_MODULUS    = 1'b1;

  // Register reset values
  localparam logic [30:0] MULT_RESET = 31'd1001;
  localparam logic [30:0] MOD_RESET  = 31'd337357757;

  // Serial step counts, as last count value
  localparam logic [4:0] MUL_LAST = 5'd30;
  localparam logic [4:0] DIV_LAST = 5'd31;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SETUP1,
    ST_DIV1,
    ST_SETUP2,
    ST_DIV2,
    ST_ADD,
    ST_FINISH
  } state_t;

endpackage

>>> hdl/lrd_if.sv
// ---------------------------------------------------------------------------
// lrd_req_if / lrd_res_if
// Valid/ready channels for draw requests and draw results.
// ---------------------------------------------------------------------------
interface lrd_req_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  req_type;
  logic signed [31:0] range_min;
  logic signed [31:0] range_max;

  modport source (output valid, output req_type, output range_min, output range_max,
                  input ready);
  modport sink   (input valid, input req_type, input range_min, input range_max,
                  output ready);
endinterface

interface lrd_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

>>> hdl/lcg_random_range_draw.sv
// ---------------------------------------------------------------------------
// lcg_random_range_draw
// Linear congruential generator with raw, ranged and reseed requests.
// ---------------------------------------------------------------------------
// One request is in work at a time; a new one is taken as soon as the
// sequencer is back in idle, even while the previous result still waits on
// the result channel. A raw draw runs the shift-add multiplier (one
// multiplier bit a cycle), the restoring divider for the modulus step (one
// quotient bit a cycle) and the setup and handoff states between them. A
// ranged draw whose maximum lies above its minimum adds a second pass of
// the same divider and an add state for the fold into the range; a ranged
// draw whose maximum is not above its minimum skips that pass and returns
// the range minimum. A zero modulus skips the first divider pass. Reseed
// and unused request codes go straight to the finish state. A stalled
// result channel adds the stall cycles once a finished result finds the
// output register still full. Configuration writes take effect at once and
// are expected only while no request is in work.
module lcg_random_range_draw (
  input  logic              clk,
  input  logic              rst,
  lrd_req_if.sink           req,
  lrd_res_if.source         res,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic       [30:0] cfg_data
);
  import lrd_pkg::*;

  state_t state, state_next;

  // configuration and generator state
  logic [30:0] multiplier;
  logic [30:0] modulus;
  logic [31:0] seed;

  // request holding
  logic        [1:0]  req_kind;
  logic signed [31:0] lo;
  logic signed [31:0] hi;

  // serial datapath
  logic [4:0]  cnt;
  logic [31:0] acc;
  logic [31:0] xsh;
  logic [30:0] mcand;
  logic        neg;
  logic [31:0] dq;
  logic [32:0] rem;
  logic [32:0] dvsr;
  logic [31:0] res_hold;

  // output register
  logic        out_valid;
  logic [31:0] out_value;

  // combinational helpers
  logic        accept;
  logic        out_free;
  logic [31:0] mag;
  logic [33:0] div_trial;
  logic [33:0] div_diff;
  logic        div_ge;
  logic [32:0] span;
  logic [32:0] rem_step;

  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || res.ready;
  assign mag       = acc[31] ? (~acc + 32'd1) : acc;
  assign div_trial = {rem, dq[31]};
  assign div_diff  = div_trial - {1'b0, dvsr};
  assign div_ge    = div_trial >= {1'b0, dvsr};
  assign rem_step  = div_ge ? div_diff[32:0] : div_trial[32:0];
  assign span      = {hi[31], hi} - {lo[31], lo} + 33'd1;

  assign req.ready = (state == ST_IDLE);
  assign res.valid = out_valid;
  assign res.value = out_value;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.req_type == REQ_RAW || req.req_type == REQ_RANGE) begin
            state_next = ST_MUL;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_MUL: begin
        if (cnt == 5'd0) state_next = ST_SETUP1;
      end
      ST_SETUP1: begin
        state_next = (modulus == 31'd0) ? ST_SETUP2 : ST_DIV1;
      end
      ST_DIV1: begin
        if (cnt == 5'd0) state_next = ST_SETUP2;
      end
      ST_SETUP2: begin
        if (req_kind == REQ_RANGE && hi > lo) begin
          state_next = ST_DIV2;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_DIV2: begin
        if (cnt == 5'd0) state_next = ST_ADD;
      end
      ST_ADD: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // configuration registers and seed
  always_ff @(posedge clk) begin
    if (rst) begin
      multiplier <= MULT_RESET;
      modulus    <= MOD_RESET;
      seed       <= 32'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MULTIPLIER: multiplier <= cfg_data;
          CFG_MODULUS:    modulus    <= cfg_data;
          default:        ;
        endcase
      end
      if (accept && req.req_type == REQ_RESEED) begin
        seed <= 32'd0;
      end else if (state == ST_SETUP2) begin
        seed <= neg ? (~rem[31:0] + 32'd1) : rem[31:0];
      end
    end
  end

  // serial multiply, divide and result datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          req_kind <= req.req_type;
          lo       <= req.range_min;
          hi       <= req.range_max;
          acc      <= 32'd0;
          xsh      <= seed + 32'd2;
          mcand    <= multiplier;
          cnt      <= MUL_LAST;
          res_hold <= 32'd0;
        end
      end
      ST_MUL: begin
        if (mcand[0]) acc <= acc + xsh;
        xsh   <= {xsh[30:0], 1'b0};
        mcand <= {1'b0, mcand[30:1]};
        cnt   <= cnt - 5'd1;
      end
      ST_SETUP1: begin
        neg  <= acc[31];
        dq   <= mag;
        dvsr <= {2'b00, modulus};
        cnt  <= DIV_LAST;
        // zero modulus: the magnitude itself is the remainder
        rem  <= (modulus == 31'd0) ? {1'b0, mag} : 33'd0;
      end
      ST_DIV1, ST_DIV2: begin
        rem <= rem_step;
        dq  <= {dq[30:0], 1'b0};
        cnt <= cnt - 5'd1;
      end
      ST_SETUP2: begin
        // raw magnitude sits in rem
        if (req_kind == REQ_RANGE) begin
          res_hold <= lo;
        end else begin
          res_hold <= rem[31:0];
        end
        dq   <= rem[31:0];
        dvsr <= span;
        rem  <= 33'd0;
        cnt  <= DIV_LAST;
      end
      ST_ADD: begin
        res_hold <= lo + rem[31:0];
      end
      ST_FINISH: begin
        if (out_free) out_value <= res_hold;
      end
      default: ;
    endcase
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

`include "assert_macros.svh"

  // a draw request starts the multiplier
  `ASSERT_NEXT(a_draw_starts_mul, clk, rst,
    accept && (req.req_type == REQ_RAW || req.req_type == REQ_RANGE), state == ST_MUL)
  // divider remainder stays below the divisor
  `ASSERT_AT(a_rem_below_dvsr, clk, rst,
    !(state == ST_DIV1 || state == ST_DIV2) || (rem < dvsr))
  // reseed clears the seed
  `ASSERT_NEXT(a_reseed_clears, clk, rst,
    accept && req.req_type == REQ_RESEED, seed == 32'd0)
  // leaving finish presents a result
  `ASSERT_NEXT(a_finish_presents, clk, rst,
    state == ST_FINISH && out_free, res.valid)

endmodule
